/* rtl/hbmm_pkg.sv */
// ----------------------------------------------------------------------------
// hbmm_pkg: shared types and constants of the hourly min/max tracker
// Item layouts for both channels and the fixed bucket geometry.
// ----------------------------------------------------------------------------
package hbmm_pkg;

  localparam int BUCKETS      = 24;
  localparam int SECS_PER_BKT = 3600;
  localparam int VALUE_WIDTH  = 32;
  localparam int TIME_WIDTH   = 32;
  // largest bucket number is (2^32-1)/3600, which fits in 21 bits
  localparam int HOUR_WIDTH   = 21;
  localparam int SLOT_WIDTH   = $clog2(BUCKETS);

  // Bucket number as (t >> 4) / 225 with 3600 = 16 * 225: multiply by
  // ceil(2^36 / 225) and keep the bits from 36 up. Exact for every 32-bit t.
  localparam int                      HOUR_PRESHIFT = 4;
  localparam int                      HOUR_SHIFT    = 36;
  localparam int                      HOUR_RECIP_W  = 29;
  localparam logic [HOUR_RECIP_W-1:0] HOUR_RECIP    = HOUR_RECIP_W'(305419897);

  // Day number as (hour >> 3) / 3 with 24 = 8 * 3: multiply by ceil(2^20 / 3)
  // and keep the bits from 20 up. Exact for every 21-bit hour.
  localparam int                      SLOT_PRESHIFT = 3;
  localparam int                      SLOT_SHIFT    = 20;
  localparam int                      SLOT_RECIP_W  = 19;
  localparam logic [SLOT_RECIP_W-1:0] SLOT_RECIP    = SLOT_RECIP_W'(349526);

  typedef struct packed {
    logic        [TIME_WIDTH-1:0]  time_seconds;
    logic signed [VALUE_WIDTH-1:0] sample_value;
  } in_item_t;

  typedef struct packed {
    logic signed [VALUE_WIDTH-1:0] overall_max;
    logic signed [VALUE_WIDTH-1:0] overall_min;
    logic                          any_valid;
  } out_item_t;

endpackage

/* rtl/hourly_bucket_min_max_tracker.sv */
// ----------------------------------------------------------------------------
// hourly_bucket_min_max_tracker: rolling 24-hour min/max over hourly buckets
// Divides the timestamp into a bucket number, retires stale buckets, folds the
// sample into its bucket and reduces all buckets into one result item.
// ----------------------------------------------------------------------------
// Flow: divide, check, retire stale buckets one at a time (up to 23), read,
//   update, reduce and drain; a jump of 24 hours or more clears all at once.
// Intake: a new item is taken only in idle, once the last result is handed
//   off; the 24-step reduction through one compare unit and the stale walk set it.
// Reset: rst_n (synchronous, active low) empties all buckets and forgets the
//   last hour; no clearing pass over the RAM is needed.
module hourly_bucket_min_max_tracker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  hbmm_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output hbmm_pkg::out_item_t out_data
);

  // Sequencer states, one-hot.
  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,  // wait for an item
    S_DIV   = 8'b0000_0010,  // scale the timestamp to a bucket number
    S_CHK   = 8'b0000_0100,  // find the slot, decide how many buckets went stale
    S_WALK  = 8'b0000_1000,  // retire stale buckets one a cycle
    S_READ  = 8'b0001_0000,  // fetch the target bucket
    S_UPD   = 8'b0010_0000,  // seed or widen the target bucket
    S_RED   = 8'b0100_0000,  // stream all buckets through the compare unit
    S_DRAIN = 8'b1000_0000   // fold the last bucket, hand off the result
  } state_t;

  localparam int VW = hbmm_pkg::VALUE_WIDTH;
  localparam int SW = hbmm_pkg::SLOT_WIDTH;
  localparam int HW = hbmm_pkg::HOUR_WIDTH;
  localparam int TW = hbmm_pkg::TIME_WIDTH;

  // Product widths of the two reciprocal multiplies.
  localparam int HP_W = TW - hbmm_pkg::HOUR_PRESHIFT + hbmm_pkg::HOUR_RECIP_W;
  localparam int SP_W = HW - hbmm_pkg::SLOT_PRESHIFT + hbmm_pkg::SLOT_RECIP_W;

  localparam logic [SW-1:0] LAST_SLOT = SW'(hbmm_pkg::BUCKETS - 1);
  localparam logic [HW-1:0] BKT_SPAN  = HW'(hbmm_pkg::BUCKETS);

  state_t state_r, state_nxt;

  // Item being worked on.
  logic        [TW-1:0] tsec_r, tsec_nxt;       // timestamp of the item
  logic signed [VW-1:0] sample_r, sample_nxt;
  logic        [HW-1:0] hour_r, hour_nxt;
  logic        [SW-1:0] slot_r, slot_nxt;       // hour mod 24

  // Bucket bookkeeping.
  logic [hbmm_pkg::BUCKETS-1:0] bkt_valid_r, bkt_valid_nxt;
  logic [HW-1:0]                last_hour_r, last_hour_nxt;
  logic [SW-1:0]                last_slot_r, last_slot_nxt;
  logic                         seen_r, seen_nxt;

  // Stale walk.
  logic [SW-1:0] ptr_r, ptr_nxt;
  logic [SW-1:0] wcnt_r, wcnt_nxt;

  // Reduction.
  logic [SW-1:0]        idx_r, idx_nxt;
  logic                 pend_r;
  logic                 vld_d_r;
  logic signed [VW-1:0] best_max_r, best_max_nxt;
  logic signed [VW-1:0] best_min_r, best_min_nxt;
  logic                 any_r, any_nxt;

  // Bucket RAM: {max, min} per bucket, registered read.
  logic [2*VW-1:0] bkt_mem [hbmm_pkg::BUCKETS];
  logic [2*VW-1:0] rd_r;
  logic [2*VW-1:0] wr_data;
  logic [SW-1:0]   raddr;
  logic            we;

  // Result register.
  logic                out_valid_r, out_valid_nxt;
  hbmm_pkg::out_item_t out_data_r, out_data_nxt;

  // Reciprocal datapath: bucket number, then its slot.
  logic [HP_W-1:0] hour_prod;
  logic [SP_W-1:0] day_prod;
  logic [HW-1:0]   day_q;
  logic [HW-1:0]   day_base;
  logic [HW-1:0]   slot_full;
  logic [HW-1:0]   hour_diff;

  // Bucket update datapath.
  logic signed [VW-1:0] cur_max, cur_min, new_max, new_min;
  logic signed [VW-1:0] rd_max, rd_min;
  logic                 slot_done;

  logic in_acc;

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // t / 3600 as (t >> 4) * ceil(2^36 / 225) >> 36
  assign hour_prod = HP_W'(tsec_r[TW-1:hbmm_pkg::HOUR_PRESHIFT]) *
                     HP_W'(hbmm_pkg::HOUR_RECIP);
  // hour / 24 as (hour >> 3) * ceil(2^20 / 3) >> 20, then hour - 24 * day
  assign day_prod  = SP_W'(hour_r[HW-1:hbmm_pkg::SLOT_PRESHIFT]) *
                     SP_W'(hbmm_pkg::SLOT_RECIP);
  assign day_q     = HW'(day_prod[SP_W-1:hbmm_pkg::SLOT_SHIFT]);
  assign day_base  = (day_q << 4) + (day_q << 3);
  assign slot_full = hour_r - day_base;

  assign hour_diff = hour_r - last_hour_r;

  assign cur_max = rd_r[2*VW-1:VW];
  assign cur_min = rd_r[VW-1:0];
  assign rd_max  = rd_r[2*VW-1:VW];
  assign rd_min  = rd_r[VW-1:0];
  assign slot_done = bkt_valid_r[slot_r];

  always_comb begin
    if (!slot_done) begin
      new_max = sample_r;
      new_min = sample_r;
    end else begin
      new_max = (sample_r > cur_max) ? sample_r : cur_max;
      new_min = (sample_r < cur_min) ? sample_r : cur_min;
    end
  end

  assign we      = (state_r == S_UPD);
  assign wr_data = {new_max, new_min};
  assign raddr   = (state_r == S_RED) ? idx_r : slot_r;

  always_ff @(posedge clk) begin
    if (we) begin
      bkt_mem[slot_r] <= wr_data;
    end
    rd_r    <= bkt_mem[raddr];
    vld_d_r <= bkt_valid_r[raddr];
  end

  // Compare unit of the reduction: fold the bucket that arrived from the RAM.
  always_comb begin
    best_max_nxt = best_max_r;
    best_min_nxt = best_min_r;
    any_nxt      = any_r;
    if (pend_r && vld_d_r) begin
      any_nxt = 1'b1;
      if (!any_r) begin
        best_max_nxt = rd_max;
        best_min_nxt = rd_min;
      end else begin
        if (rd_max > best_max_r) begin
          best_max_nxt = rd_max;
        end
        if (rd_min < best_min_r) begin
          best_min_nxt = rd_min;
        end
      end
    end
    if (state_r == S_UPD) begin
      // start a fresh reduction
      best_max_nxt = '0;
      best_min_nxt = '0;
      any_nxt      = 1'b0;
    end
  end

  // Sequencer.
  always_comb begin
    state_nxt     = state_r;
    tsec_nxt      = tsec_r;
    sample_nxt    = sample_r;
    hour_nxt      = hour_r;
    slot_nxt      = slot_r;
    bkt_valid_nxt = bkt_valid_r;
    last_hour_nxt = last_hour_r;
    last_slot_nxt = last_slot_r;
    seen_nxt      = seen_r;
    ptr_nxt       = ptr_r;
    wcnt_nxt      = wcnt_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    // result taken downstream
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          tsec_nxt   = in_data.time_seconds;
          sample_nxt = in_data.sample_value;
          state_nxt  = S_DIV;
        end
      end
      S_DIV: begin
        hour_nxt  = hour_prod[HP_W-1:hbmm_pkg::HOUR_SHIFT];
        state_nxt = S_CHK;
      end
      S_CHK: begin
        slot_nxt  = slot_full[SW-1:0];
        state_nxt = S_READ;
        if (seen_r && (hour_r > last_hour_r)) begin
          if (hour_diff >= BKT_SPAN) begin
            bkt_valid_nxt = '0;
          end else begin
            ptr_nxt   = (last_slot_r == LAST_SLOT) ? '0 : last_slot_r + 1'b1;
            wcnt_nxt  = hour_diff[SW-1:0];
            state_nxt = S_WALK;
          end
        end
      end
      S_WALK: begin
        bkt_valid_nxt[ptr_r] = 1'b0;
        ptr_nxt  = (ptr_r == LAST_SLOT) ? '0 : ptr_r + 1'b1;
        wcnt_nxt = wcnt_r - 1'b1;
        if (wcnt_r == SW'(1)) begin
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        state_nxt = S_UPD;
      end
      S_UPD: begin
        bkt_valid_nxt[slot_r] = 1'b1;
        last_hour_nxt = hour_r;
        last_slot_nxt = slot_r;
        seen_nxt      = 1'b1;
        idx_nxt       = '0;
        state_nxt     = S_RED;
      end
      S_RED: begin
        idx_nxt = idx_r + 1'b1;
        if (idx_r == LAST_SLOT) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        // hold until the result register is free
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.overall_max = best_max_nxt;
          out_data_nxt.overall_min = best_min_nxt;
          out_data_nxt.any_valid   = any_nxt;
          state_nxt                = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      bkt_valid_r <= '0;
      last_hour_r <= '0;
      last_slot_r <= '0;
      seen_r      <= 1'b0;
      slot_r      <= '0;
      ptr_r       <= '0;
      idx_r       <= '0;
      pend_r      <= 1'b0;
      any_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      bkt_valid_r <= bkt_valid_nxt;
      last_hour_r <= last_hour_nxt;
      last_slot_r <= last_slot_nxt;
      seen_r      <= seen_nxt;
      slot_r      <= slot_nxt;
      ptr_r       <= ptr_nxt;
      idx_r       <= idx_nxt;
      pend_r      <= (state_r == S_RED);
      any_r       <= any_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers, no reset.
  always_ff @(posedge clk) begin
    tsec_r     <= tsec_nxt;
    sample_r   <= sample_nxt;
    hour_r     <= hour_nxt;
    wcnt_r     <= wcnt_nxt;
    best_max_r <= best_max_nxt;
    best_min_r <= best_min_nxt;
    out_data_r <= out_data_nxt;
  end

  // Checks.
  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    (slot_r <= LAST_SLOT) && (last_slot_r <= LAST_SLOT))
    else $error("bucket slot out of range");

  a_upd_marks: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_UPD) |=> bkt_valid_r[last_slot_r])
    else $error("updated bucket not marked valid");

  a_res_any: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> out_data_r.any_valid)
    else $error("result after a sample shows no valid bucket");

  a_res_order: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> (out_data_r.overall_max >= out_data_r.overall_min))
    else $error("overall max below overall min");

endmodule

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench: self-checking bench for hourly_bucket_min_max_tracker
// Drives timestamped Q16.16 samples through the valid/stall input channel. A
// behavioral copy of the 24-bucket tracker predicts each result item, and the
// bench checks every field on the output channel. The run starts with a
// directed table, then walks random time sequences with random idling on
// both sides.
// ----------------------------------------------------------------------------
module testbench;
  import hbmm_pkg::*;

  localparam int CLK_HALF    = 10;
  localparam int RESET_CYCLES = 12;
  localparam int RANDOM_ITEMS = 1200;
  localparam int DRAIN_CYCLES = 120;       // worst-case latency plus margin
  localparam int LIMIT_CYCLES = 1_000_000;
  localparam int MAX_REPORTS  = 10;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  // Quiet window: neither side idles while this is set.
  bit quiet = 1'b0;

  hourly_bucket_min_max_tracker uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Tracker shadow state
  // --------------------------------------------------------------------------
  logic signed [VALUE_WIDTH-1:0] trk_max   [BUCKETS];
  logic signed [VALUE_WIDTH-1:0] trk_min   [BUCKETS];
  logic                          trk_valid [BUCKETS];
  logic [HOUR_WIDTH-1:0]         trk_last_hour = '0;
  logic                          trk_seen = 1'b0;

  out_item_t pending_extremes[$];

  int items_sent    = 0;
  int results_seen  = 0;
  int mismatches    = 0;
  int hour_advances = 0;
  int full_wipes    = 0;
  int backward_hops = 0;

  initial begin
    for (int i = 0; i < BUCKETS; i++) begin
      trk_max[i]   = '0;
      trk_min[i]   = '0;
      trk_valid[i] = 1'b0;
    end
  end

  // Fold one item into the shadow buckets and return the overall extremes.
  function automatic out_item_t predict_extremes(input in_item_t item);
    logic [TIME_WIDTH-1:0]         hour_full;
    logic [HOUR_WIDTH-1:0]         hour;
    int                            slot;
    int                            span;
    logic signed [VALUE_WIDTH-1:0] v;
    out_item_t                     res;

    hour_full = item.time_seconds / TIME_WIDTH'(SECS_PER_BKT);
    hour      = hour_full[HOUR_WIDTH-1:0];
    slot      = int'(hour % HOUR_WIDTH'(BUCKETS));
    v         = item.sample_value;
    res       = '0;

    // Retire every bucket passed over since the last item.
    if (trk_seen && hour > trk_last_hour) begin
      span = int'(hour - trk_last_hour);
      hour_advances++;
      if (span >= BUCKETS) begin
        full_wipes++;
        for (int i = 0; i < BUCKETS; i++) begin
          trk_max[i]   = '0;
          trk_min[i]   = '0;
          trk_valid[i] = 1'b0;
        end
      end else begin
        for (int k = 1; k <= span; k++) begin
          trk_max[(int'(trk_last_hour) + k) % BUCKETS]   = '0;
          trk_min[(int'(trk_last_hour) + k) % BUCKETS]   = '0;
          trk_valid[(int'(trk_last_hour) + k) % BUCKETS] = 1'b0;
        end
      end
    end else if (trk_seen && hour < trk_last_hour) begin
      backward_hops++;
    end

    // Seed an empty bucket, otherwise widen it.
    if (!trk_valid[slot]) begin
      trk_max[slot]   = v;
      trk_min[slot]   = v;
      trk_valid[slot] = 1'b1;
    end else begin
      if (v > trk_max[slot]) trk_max[slot] = v;
      if (v < trk_min[slot]) trk_min[slot] = v;
    end

    trk_last_hour = hour;
    trk_seen      = 1'b1;

    for (int i = 0; i < BUCKETS; i++) begin
      if (trk_valid[i]) begin
        if (!res.any_valid) begin
          res.overall_max = trk_max[i];
          res.overall_min = trk_min[i];
          res.any_valid   = 1'b1;
        end else begin
          if (trk_max[i] > res.overall_max) res.overall_max = trk_max[i];
          if (trk_min[i] < res.overall_min) res.overall_min = trk_min[i];
        end
      end
    end
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Input driver: called at a falling edge, returns at a falling edge
  // --------------------------------------------------------------------------
  task automatic send_item(input in_item_t item, input bit has_fixed,
                           input out_item_t fixed);
    out_item_t predicted;
    // Idle a random number of cycles; drop valid only when idling.
    if (!quiet && $urandom_range(99) < 17) begin
      in_valid <= 1'b0;
      @(negedge clk);
      while (!quiet && $urandom_range(99) < 17) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    // Hold the item until the block takes it.
    do @(posedge clk); while (in_stall);
    predicted = predict_extremes(item);
    pending_extremes.push_back(has_fixed ? fixed : predicted);
    items_sent++;
    @(negedge clk);
  endtask

  // Hold off the sender until every expected item has come back.
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    while (pending_extremes.size() != 0) @(negedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Output side: random stall, check each accepted item
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    out_stall <= !quiet && ($urandom_range(99) < 17);
  end

  always @(posedge clk) begin : check_results
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (pending_extremes.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("ERROR: result with nothing pending: max=%h min=%h any=%b",
                   out_data.overall_max, out_data.overall_min, out_data.any_valid);
      end else begin
        want = pending_extremes.pop_front();
        if (out_data.overall_max !== want.overall_max ||
            out_data.overall_min !== want.overall_min ||
            out_data.any_valid   !== want.any_valid) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("ERROR: result %0d: expected max=%h min=%h any=%b, got max=%h min=%h any=%b",
                     results_seen, want.overall_max, want.overall_min, want.any_valid,
                     out_data.overall_max, out_data.overall_min, out_data.any_valid);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Directed table: fixed expectations only where obvious
  // --------------------------------------------------------------------------
  typedef struct {
    logic [31:0] t;
    logic [31:0] v;
    bit          has_fixed;
    logic [31:0] want_max;
    logic [31:0] want_min;
  } row_t;

  localparam int DIRECTED_ROWS = 16;

  row_t directed [DIRECTED_ROWS] = '{
    // first item after reset: no clearing, bucket seeded
    '{32'd0,          32'h7FFF_FFFF, 1'b1, 32'h7FFF_FFFF, 32'h7FFF_FFFF},
    // same hour: widen down to the most negative value
    '{32'd1,          32'h8000_0000, 1'b1, 32'h7FFF_FFFF, 32'h8000_0000},
    '{32'd3599,       32'h0000_0000, 1'b1, 32'h7FFF_FFFF, 32'h8000_0000},
    // next hour: only bucket 1 is retired
    '{32'd3600,       32'h0000_0005, 1'b1, 32'h7FFF_FFFF, 32'h8000_0000},
    // step of 22 hours
    '{32'd82810,      32'hFFFF_FFFF, 1'b1, 32'h7FFF_FFFF, 32'h8000_0000},
    // wrap to bucket 0: the old extremes go away
    '{32'd86400,      32'h0000_0001, 1'b0, '0, '0},
    // time going backwards: no clearing
    '{32'd7200,       32'hFFFF_FF9C, 1'b0, '0, '0},
    '{32'd7205,       32'h0000_0064, 1'b0, '0, '0},
    // step of exactly 24 hours wipes all
    '{32'd93600,      32'h0001_0000, 1'b1, 32'h0001_0000, 32'h0001_0000},
    // step of 23 hours keeps only the current bucket's neighbor
    '{32'd176400,     32'h0001_8000, 1'b0, '0, '0},
    // largest timestamp: huge jump wipes all
    '{32'hFFFF_FFFF,  32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF},
    '{32'hFFFF_FFFF,  32'h8000_0000, 1'b0, '0, '0},
    // back to time zero
    '{32'd0,          32'h7FFF_FFFF, 1'b0, '0, '0},
    '{32'd3599,       32'h0000_0001, 1'b0, '0, '0},
    '{32'hFFFF_FFF0,  32'hAAAA_AAAA, 1'b1, 32'hAAAA_AAAA, 32'hAAAA_AAAA},
    '{32'hFFFF_FFFF,  32'h5555_5555, 1'b0, '0, '0}
  };

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    in_item_t    item;
    out_item_t   fixed;
    logic [31:0] cur_time;
    logic [31:0] base_value;
    int          pick;

    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Walk the directed table.
    for (int r = 0; r < DIRECTED_ROWS; r++) begin
      item.time_seconds = directed[r].t;
      item.sample_value = directed[r].v;
      fixed.overall_max = directed[r].want_max;
      fixed.overall_min = directed[r].want_min;
      fixed.any_valid   = 1'b1;
      send_item(item, directed[r].has_fixed, fixed);
    end
    wait_for_drain();

    // Random sequences: mostly forward time with realistic steps.
    cur_time   = $urandom();
    base_value = 32'h0014_0000;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      quiet = (n >= 300 && n < 500);
      if (n == 700) wait_for_drain();

      pick = $urandom_range(99);
      if (pick < 55)
        cur_time += $urandom_range(1200);
      else if (pick < 75)
        cur_time += $urandom_range(1, 25) * 3600 + $urandom_range(3599);
      else if (pick < 83)
        cur_time += $urandom_range(20 * 3600, 30 * 3600);
      else if (pick < 91)
        cur_time = $urandom();
      else if (pick < 94)
        cur_time = 32'hFFFF_FFFF - $urandom_range(3 * 3600);
      else
        cur_time -= $urandom_range(5 * 3600);

      pick = $urandom_range(99);
      if (pick < 10) begin
        case ($urandom_range(3))
          0: item.sample_value = 32'h7FFF_FFFF;
          1: item.sample_value = 32'h8000_0000;
          2: item.sample_value = 32'h0000_0000;
          default: item.sample_value = 32'hFFFF_FFFF;
        endcase
      end else if (pick < 55) begin
        // drift a sensor-like reading around a slowly moving base
        base_value += $urandom_range(32'h0002_0000) - 32'h0001_0000;
        item.sample_value = base_value + $urandom_range(32'h0000_FFFF) - 32'h0000_8000;
      end else begin
        item.sample_value = $urandom();
      end
      item.time_seconds = cur_time;
      send_item(item, 1'b0, '0);
    end
    quiet = 1'b0;
    in_valid <= 1'b0;

    // Let the last items come back, then watch for strays.
    while (pending_extremes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Summary: %0d items sent, %0d results checked, %0d mismatches",
             items_sent, results_seen, mismatches);
    $display("Summary: %0d hour advances, %0d full wipes, %0d backward hops",
             hour_advances, full_wipes, backward_hops);
    if (mismatches == 0 && pending_extremes.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Hard stop if the block hangs.
  initial begin : watchdog
    #(LIMIT_CYCLES * 2 * CLK_HALF);
    $display("Timeout after %0d cycles", LIMIT_CYCLES);
    $display("Verification failed");
    $finish;
  end

endmodule
